// ===== hdl/pbb_pkg.sv =====
// shared types, constants and color packing for the palette bitmap blitter
// no dependencies
`default_nettype none

package pbb_pkg;

  localparam int PBB_PALETTE_DEPTH = 256;
  localparam int PBB_MAX_DIMENSION = 4096;
  localparam int PBB_OFF_W = 26;

  typedef enum logic [2:0] {
    REG_INDEX_BITS  = 3'd0,
    REG_IMG_WIDTH   = 3'd1,
    REG_IMG_HEIGHT  = 3'd2,
    REG_ORIGIN_X    = 3'd3,
    REG_ORIGIN_Y    = 3'd4,
    REG_SCR_WIDTH   = 3'd5,
    REG_SCR_BPP     = 3'd6,
    REG_COLOR_LAYOUT = 3'd7
  } pbb_reg_e;

  typedef enum logic [1:0] {
    IDX_BITS_1 = 2'd0,
    IDX_BITS_4 = 2'd1,
    IDX_BITS_8 = 2'd2,
    IDX_BITS_X = 2'd3
  } pbb_idx_bits_e;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [23:0] rgb;
  } pbb_wr_req_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } pbb_rd_req_t;

  function automatic logic [31:0] pbb_place(logic [7:0] c, logic [7:0] size, logic [7:0] pos);
    logic [3:0]  sz;
    logic [7:0]  v;
    logic [63:0] w;
    sz = (size > 8'd8) ? 4'd8 : size[3:0];
    v  = c >> (4'd8 - sz);
    w  = 64'(v) << pos[4:0];
    return (pos >= 8'd32) ? 32'd0 : w[31:0];
  endfunction

  function automatic logic [31:0] pbb_pack(logic [23:0] rgb, logic [47:0] layout);
    return pbb_place(rgb[23:16], layout[7:0], layout[15:8])
         | pbb_place(rgb[15:8], layout[23:16], layout[31:24])
         | pbb_place(rgb[7:0], layout[39:32], layout[47:40]);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pbb_channels.sv =====
// request and result channel interfaces of the palette bitmap blitter
// depends on pbb_pkg for the offset width
`default_nettype none

interface pbb_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;
  logic [7:0] data_byte;

  modport source (
    output valid, kind, palette_index, palette_red, palette_green, palette_blue, data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, palette_index, palette_red, palette_green, palette_blue, data_byte,
    output ready
  );
endinterface

interface pbb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pbb_pkg::PBB_OFF_W-1:0] byte_offset;
  logic [31:0]                   pixel_value;
  logic [2:0]                    pixel_bytes;
  logic                          last_of_byte;

  modport source (
    output valid, byte_offset, pixel_value, pixel_bytes, last_of_byte,
    input  ready
  );
  modport sink (
    input  valid, byte_offset, pixel_value, pixel_bytes, last_of_byte,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/palette_bitmap_blitter_unit.sv =====
// palette bitmap blitter top level: walk counters, offset math, pixel issue
// depends on pbb_pkg, pbb_channels and pbb_palette
`default_nettype none

// channel  dir  width  carries
// req_i    in   41     palette entry write or one bitmap data byte
// rsp_o    out  62     byte offset, packed pixel, byte count, last-of-byte flag
// cfg      in   52     write enable, register index, write data
//
// a palette write is taken from idle; a data byte is taken from idle, then runs
// the offset states S_MUL and S_OFF, then issues one pixel per cycle (up to
// eight) while the output does not stall, set by the single palette read port
// a padding byte or one past the image issues no pixels; the state stays idle
// new requests wait until the current byte's pixels are all issued
// results sit in an output register; the read pipeline holds while it stalls
// reset clears only control and config state; palette undefined until written

module palette_bitmap_blitter_unit #(
  parameter int PALETTE_DEPTH = pbb_pkg::PBB_PALETTE_DEPTH,
  parameter int MAX_DIMENSION = pbb_pkg::PBB_MAX_DIMENSION
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  pbb_req_if.sink      req_i,
  pbb_rsp_if.source    rsp_o,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [47:0]  cfg_wdata_i
);
  import pbb_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int RB_W  = $clog2(MAX_DIMENSION + 4);
  localparam int SY_W  = ((DIM_W > 12) ? DIM_W : 12) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_OFF  = 4'b0100,
    S_PIX  = 4'b1000
  } pbb_state_e;

  // configuration
  logic [1:0]  idx_code_q;
  logic [12:0] img_w_q;
  logic [13:0] img_h_q;
  logic [11:0] org_x_q;
  logic [11:0] org_y_q;
  logic [12:0] scr_w_q;
  logic [2:0]  scr_bpp_q;
  logic [47:0] layout_q;

  // walk state
  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [RB_W-1:0]  rb_q, rb_d;

  pbb_state_e state_q, state_d;

  logic [7:0]           data_q;
  logic [3:0]           cnt_q;
  logic [SY_W-1:0]      sy_q;
  logic [SY_W-1:0]      sx_q;
  logic [PBB_OFF_W-1:0] prod_q;
  logic [PBB_OFF_W-1:0] off_q;

  logic                 p1_valid_q;
  logic [PBB_OFF_W-1:0] p1_off_q;
  logic                 p1_last_q;
  logic                 p1_oob_q;

  logic                 out_valid_q;
  logic [PBB_OFF_W-1:0] out_off_q;
  logic [31:0]          out_value_q;
  logic                 out_last_q;

  // derived geometry
  logic [DIM_W-1:0] width_sat;
  logic             h_neg;
  logic [13:0]      h_abs;
  logic [DIM_W-1:0] hmag;
  logic [RB_W:0]    rb_ext;
  logic [RB_W:0]    rb_sum;
  logic [RB_W-1:0]  row_bytes;
  logic [RB_W:0]    pad_sum;
  logic [RB_W-1:0]  padded;
  logic [3:0]       per_byte;
  logic [3:0]       n_bits;
  logic [DIM_W-1:0] remaining;
  logic [3:0]       count;
  logic             walk_live;
  logic             byte_active;
  logic [DIM_W-1:0] sy_row;
  logic [2:0]       bpp;
  logic [RB_W-1:0]  rb_inc;

  // pixel issue
  logic        load_out;
  logic        issue;
  logic [7:0]  idx;
  logic        idx_oob;
  logic        acc;
  logic [23:0] rdata;

  pbb_wr_req_t wr_req;
  pbb_rd_req_t rd_req;

  always_comb begin
    width_sat = (32'(img_w_q) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(img_w_q);
    h_neg     = img_h_q[13];
    h_abs     = h_neg ? (14'd0 - img_h_q) : img_h_q;
    hmag      = (32'(h_abs) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(h_abs);
    rb_ext    = (RB_W + 1)'(width_sat);
    case (pbb_idx_bits_e'(idx_code_q))
      IDX_BITS_1: begin
        rb_sum   = (rb_ext + (RB_W + 1)'(7)) >> 3;
        per_byte = 4'd8;
        n_bits   = 4'd1;
      end
      IDX_BITS_4: begin
        rb_sum   = (rb_ext + (RB_W + 1)'(1)) >> 1;
        per_byte = 4'd2;
        n_bits   = 4'd4;
      end
      default: begin
        rb_sum   = rb_ext;
        per_byte = 4'd1;
        n_bits   = 4'd8;
      end
    endcase
    row_bytes   = rb_sum[RB_W-1:0];
    pad_sum     = {1'b0, row_bytes} + (RB_W + 1)'(3);
    padded      = pad_sum[RB_W-1:0] & ~RB_W'(3);
    remaining   = width_sat - col_q;
    count       = (32'(remaining) > 32'(per_byte)) ? per_byte : 4'(remaining);
    walk_live   = (width_sat != '0) && (row_q < hmag);
    byte_active = walk_live && (rb_q < row_bytes);
    sy_row      = h_neg ? row_q : (hmag - DIM_W'(1) - row_q);
    if (scr_bpp_q == 3'd0) begin
      bpp = 3'd1;
    end else if (scr_bpp_q > 3'd4) begin
      bpp = 3'd4;
    end else begin
      bpp = scr_bpp_q;
    end
    rb_inc = rb_q + RB_W'(1);
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign acc         = req_i.valid && (state_q == S_IDLE);

  // walk counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    rb_d  = rb_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
      rb_d  = '0;
    end else if (acc && req_i.kind && walk_live) begin
      if (byte_active) begin
        col_d = col_q + DIM_W'(count);
        if (rb_inc == row_bytes) begin
          col_d = '0;
        end
      end
      rb_d = rb_inc;
      if (rb_inc >= padded) begin
        rb_d  = '0;
        col_d = '0;
        row_d = row_q + DIM_W'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && req_i.kind && byte_active && (count != 4'd0)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_OFF;
      S_OFF: state_d = S_PIX;
      S_PIX: begin
        if (issue && (cnt_q == 4'd1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (pbb_idx_bits_e'(idx_code_q))
      IDX_BITS_1: idx = {7'd0, data_q[7]};
      IDX_BITS_4: idx = {4'd0, data_q[7:4]};
      default:    idx = data_q;
    endcase
    idx_oob  = ({1'b0, idx} >= 9'(PALETTE_DEPTH));
    load_out = p1_valid_q && (!out_valid_q || rsp_o.ready);
    issue    = (state_q == S_PIX) && (!p1_valid_q || load_out);
  end

  assign wr_req = '{
    en:   acc && !req_i.kind && ({1'b0, req_i.palette_index} < 9'(PALETTE_DEPTH)),
    addr: req_i.palette_index,
    rgb:  {req_i.palette_red, req_i.palette_green, req_i.palette_blue}
  };
  assign rd_req = '{en: issue && !idx_oob, addr: idx};

  pbb_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_code_q <= 2'd2;
      img_w_q    <= 13'd1;
      img_h_q    <= 14'd1;
      org_x_q    <= '0;
      org_y_q    <= '0;
      scr_w_q    <= 13'd1;
      scr_bpp_q  <= 3'd4;
      layout_q   <= '0;
    end else if (cfg_we_i) begin
      case (pbb_reg_e'(cfg_index_i))
        REG_INDEX_BITS:   idx_code_q <= cfg_wdata_i[1:0];
        REG_IMG_WIDTH:    img_w_q    <= cfg_wdata_i[12:0];
        REG_IMG_HEIGHT:   img_h_q    <= cfg_wdata_i[13:0];
        REG_ORIGIN_X:     org_x_q    <= cfg_wdata_i[11:0];
        REG_ORIGIN_Y:     org_y_q    <= cfg_wdata_i[11:0];
        REG_SCR_WIDTH:    scr_w_q    <= cfg_wdata_i[12:0];
        REG_SCR_BPP:      scr_bpp_q  <= cfg_wdata_i[2:0];
        REG_COLOR_LAYOUT: layout_q   <= cfg_wdata_i;
        default:          layout_q   <= layout_q;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      rb_q        <= '0;
      cnt_q       <= '0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      rb_q    <= rb_d;
      if (state_q == S_IDLE) begin
        cnt_q <= count;
      end else if (issue) begin
        cnt_q <= cnt_q - 4'd1;
      end
      if (issue) begin
        p1_valid_q <= 1'b1;
      end else if (load_out) begin
        p1_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (acc) begin
      data_q <= req_i.data_byte;
      sy_q   <= SY_W'(org_y_q) + SY_W'(sy_row);
      sx_q   <= SY_W'(org_x_q) + SY_W'(col_q);
    end
    if (state_q == S_MUL) begin
      prod_q <= PBB_OFF_W'(32'(sy_q) * 32'(scr_w_q));
    end
    if (state_q == S_OFF) begin
      off_q <= PBB_OFF_W'(32'(prod_q + PBB_OFF_W'(sx_q)) * 32'(bpp));
    end else if (issue) begin
      off_q  <= off_q + PBB_OFF_W'(bpp);
      data_q <= data_q << n_bits;
    end
    if (issue) begin
      p1_off_q  <= off_q;
      p1_last_q <= (cnt_q == 4'd1);
      p1_oob_q  <= idx_oob;
    end
    if (load_out) begin
      out_off_q   <= p1_off_q;
      out_value_q <= p1_oob_q ? 32'd0 : pbb_pack(rdata, layout_q);
      out_last_q  <= p1_last_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.byte_offset  = out_off_q;
  assign rsp_o.pixel_value  = out_value_q;
  assign rsp_o.pixel_bytes  = bpp;
  assign rsp_o.last_of_byte = out_last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && !load_out) |=> p1_valid_q)
    else $error("pending pixel dropped before reaching the output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PIX) |-> (cnt_q != 4'd0))
    else $error("pixel issue with no pixels left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_OFF))
    else $error("offset sequence broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_sat != '0) |-> (rb_q < padded))
    else $error("row byte count past padded row length");
`endif

endmodule

`default_nettype wire

// ===== hdl/pbb_palette.sv =====
// palette memory: one write port, one read port with registered read data
// depends on pbb_pkg for the port structs
`default_nettype none

module pbb_palette #(
  parameter int PALETTE_DEPTH = pbb_pkg::PBB_PALETTE_DEPTH
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pbb_pkg::pbb_wr_req_t wr_i,
  input  pbb_pkg::pbb_rd_req_t rd_i,
  output logic [23:0]          rdata_o
);
  import pbb_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] mem_q [PALETTE_DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.rgb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_i.en && rd_i.en))
    else $error("palette read and write in the same cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> (9'(wr_i.addr) < 9'(PALETTE_DEPTH)))
    else $error("palette write beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i.en |-> (9'(rd_i.addr) < 9'(PALETTE_DEPTH)))
    else $error("palette read beyond depth");
`endif

endmodule

`default_nettype wire
